@@ hw/rtl/trsg_pkg.sv @@
package trsg_pkg;

   // Field and register widths
   localparam int COORD_BITS = 10;
   localparam int POINT_BITS = 11;
   localparam int SIZE_BITS  = 11;
   localparam int PCT_BITS   = 7;
   localparam int TIME_BITS  = 32;
   localparam int PROD_BITS  = SIZE_BITS + PCT_BITS;
   localparam int CALC_BITS  = ((COORD_BITS > POINT_BITS) ? COORD_BITS : POINT_BITS) + 2;
   localparam int WIDE_BITS  = POINT_BITS + 4;
   localparam int ADDR_BITS  = 5;
   localparam int DATA_BITS  = 32;

   // Gesture thresholds
   localparam int SWIPE_DOWN_MIN  = 40;
   localparam int HOME_MAX_MS     = 500;
   localparam int HOME_HEIGHT_DIV = 5;
   localparam int PERCENT         = 100;

   // Register reset values
   localparam logic [SIZE_BITS-1:0] RESET_WIDTH      = SIZE_BITS'(240);
   localparam logic [SIZE_BITS-1:0] RESET_HEIGHT     = SIZE_BITS'(320);
   localparam logic [PCT_BITS-1:0]  RESET_TOP_PCT    = PCT_BITS'(15);
   localparam logic [PCT_BITS-1:0]  RESET_BOTTOM_PCT = PCT_BITS'(75);

   typedef logic signed [POINT_BITS-1:0] point_type;
   typedef logic signed [CALC_BITS-1:0]  calc_type;

   typedef enum logic [1:0] {
      ROT_0   = 2'd0,
      ROT_90  = 2'd1,
      ROT_180 = 2'd2,
      ROT_270 = 2'd3
   } rotation_type;

   typedef enum logic [2:0] {
      REG_ROTATION      = 3'd0,
      REG_SCREEN_WIDTH  = 3'd1,
      REG_SCREEN_HEIGHT = 3'd2,
      REG_TOP_ZONE      = 3'd3,
      REG_BOTTOM_ZONE   = 3'd4
   } reg_index_type;

   // Clamp a transformed coordinate to the signed point range
   function automatic point_type sat_point(calc_type v);
      calc_type hi;
      calc_type lo;
      hi = calc_type'((2 ** (POINT_BITS - 1)) - 1);
      lo = -calc_type'(2 ** (POINT_BITS - 1));
      if (v > hi) begin
         return point_type'(hi);
      end else if (v < lo) begin
         return point_type'(lo);
      end
      return point_type'(v);
   endfunction

endpackage

@@ hw/rtl/touch_rotation_and_swipe_gestures.sv @@
// Channel  Direction  Beat contents
// -------  ---------  ----------------------------------------------------------
// req      in         is_pressed, raw_x, raw_y, now_ms (one touch sample)
// rsp      out        pressed_out, point_x, point_y, home/swipe-down pulses
// apb      in/out     rotation, screen size, top and bottom zone percents
//
// One sample per cycle while rsp_ready is high: a sample is registered in the
// input register, then rotation, saturation and gesture compares land in the
// result register, which drives the rsp channel.
// Touch state updates as a sample moves to the result register, so the next
// sample always sees it. rsp_ready low with a full result register holds both
// registers; req_ready drops only in reset or when both are full and rsp_ready
// is low. Reset is synchronous and clears all control and touch state; the zone
// products are registered and follow register writes in the cycle after.
module touch_rotation_and_swipe_gestures (
   input  logic                                      clock,
   input  logic                                      reset,
   // sample channel
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic                                      req_is_pressed,
   input  logic [trsg_pkg::COORD_BITS-1:0]           req_raw_x,
   input  logic [trsg_pkg::COORD_BITS-1:0]           req_raw_y,
   input  logic [trsg_pkg::TIME_BITS-1:0]            req_now_ms,
   // result channel
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic                                      rsp_pressed_out,
   output logic signed [trsg_pkg::POINT_BITS-1:0]    rsp_point_x,
   output logic signed [trsg_pkg::POINT_BITS-1:0]    rsp_point_y,
   output logic                                      rsp_home_gesture,
   output logic                                      rsp_swipe_down_left,
   output logic                                      rsp_swipe_down_right,
   // register port
   input  logic                                      psel,
   input  logic                                      penable,
   input  logic                                      pwrite,
   input  logic [trsg_pkg::ADDR_BITS-1:0]            paddr,
   input  logic [trsg_pkg::DATA_BITS-1:0]            pwdata,
   output logic [trsg_pkg::DATA_BITS-1:0]            prdata,
   output logic                                      pready
);
   import trsg_pkg::*;

   // Configuration registers
   rotation_type               rotation_ff;
   logic [SIZE_BITS-1:0]       screen_width_ff;
   logic [SIZE_BITS-1:0]       screen_height_ff;
   logic [PCT_BITS-1:0]        top_pct_ff;
   logic [PCT_BITS-1:0]        bottom_pct_ff;
   reg_index_type              reg_index;
   logic                       csr_write;

   // Derived zone values
   logic [SIZE_BITS-1:0]       eff_h_in, eff_h_ff;
   logic [PROD_BITS-1:0]       top_prod_in, top_prod_ff;
   logic [PROD_BITS-1:0]       bot_prod_in, bot_prod_ff;
   logic [SIZE_BITS-2:0]       half_w_ff;

   // Input register
   logic                       in_valid_ff;
   logic                       in_pressed_ff;
   logic [COORD_BITS-1:0]      in_raw_x_ff;
   logic [COORD_BITS-1:0]      in_raw_y_ff;
   logic [TIME_BITS-1:0]       in_now_ff;

   // Touch state
   logic                       touch_active_ff, touch_active_in;
   point_type                  start_y_ff, start_y_in;
   point_type                  last_y_ff, last_y_in;
   logic [TIME_BITS-1:0]       start_time_ff, start_time_in;
   point_type                  panel_start_x_ff, panel_start_x_in;
   logic                       panel_fired_ff, panel_fired_in;

   // Result register
   logic                       rsp_valid_ff;
   logic                       rsp_pressed_ff;
   point_type                  rsp_x_ff, rsp_x_in;
   point_type                  rsp_y_ff, rsp_y_in;
   logic                       rsp_home_ff, rsp_home_in;
   logic                       rsp_left_ff, rsp_left_in;
   logic                       rsp_right_ff, rsp_right_in;

   // Datapath
   logic                       advance;
   logic                       fire;
   calc_type                   w_c, h_c, rx_c, ry_c, tx_c, ty_c;
   point_type                  tx, ty;
   point_type                  psx, psy;
   logic                       fired_cur;
   logic [PROD_BITS-1:0]       top_lhs;
   logic [PROD_BITS-1:0]       low_lhs;
   logic signed [POINT_BITS:0] drop;
   logic signed [POINT_BITS:0] up;
   logic signed [WIDE_BITS-1:0] up5;
   logic [TIME_BITS-1:0]       elapsed;

   // Register port
   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[ADDR_BITS-1:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff      <= ROT_0;
         screen_width_ff  <= RESET_WIDTH;
         screen_height_ff <= RESET_HEIGHT;
         top_pct_ff       <= RESET_TOP_PCT;
         bottom_pct_ff    <= RESET_BOTTOM_PCT;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_ROTATION:      rotation_ff      <= rotation_type'(pwdata[1:0]);
            REG_SCREEN_WIDTH:  screen_width_ff  <= pwdata[SIZE_BITS-1:0];
            REG_SCREEN_HEIGHT: screen_height_ff <= pwdata[SIZE_BITS-1:0];
            REG_TOP_ZONE:      top_pct_ff       <= pwdata[PCT_BITS-1:0];
            REG_BOTTOM_ZONE:   bottom_pct_ff    <= pwdata[PCT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (reg_index)
         REG_ROTATION:      prdata = DATA_BITS'(rotation_ff);
         REG_SCREEN_WIDTH:  prdata = DATA_BITS'(screen_width_ff);
         REG_SCREEN_HEIGHT: prdata = DATA_BITS'(screen_height_ff);
         REG_TOP_ZONE:      prdata = DATA_BITS'(top_pct_ff);
         REG_BOTTOM_ZONE:   prdata = DATA_BITS'(bottom_pct_ff);
         default:           prdata = '0;
      endcase
   end

   // Scale the zones by height ahead of the samples
   assign eff_h_in    = (rotation_ff == ROT_90 || rotation_ff == ROT_270) ?
                        screen_width_ff : screen_height_ff;
   assign top_prod_in = PROD_BITS'(eff_h_in) * PROD_BITS'(top_pct_ff);
   assign bot_prod_in = PROD_BITS'(eff_h_in) * PROD_BITS'(bottom_pct_ff);

   always_ff @(posedge clock) begin
      eff_h_ff    <= eff_h_in;
      top_prod_ff <= top_prod_in;
      bot_prod_ff <= bot_prod_in;
      half_w_ff   <= screen_width_ff[SIZE_BITS-1:1];
   end

   // Handshake: move a sample on whenever the result register frees up
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !reset && (!in_valid_ff || advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_pressed_ff <= req_is_pressed;
         in_raw_x_ff   <= req_raw_x;
         in_raw_y_ff   <= req_raw_y;
         in_now_ff     <= req_now_ms;
      end
   end

   // Rotate the point by quarter turns
   assign w_c  = {{(CALC_BITS - SIZE_BITS){1'b0}}, screen_width_ff};
   assign h_c  = {{(CALC_BITS - SIZE_BITS){1'b0}}, screen_height_ff};
   assign rx_c = {{(CALC_BITS - COORD_BITS){1'b0}}, in_raw_x_ff};
   assign ry_c = {{(CALC_BITS - COORD_BITS){1'b0}}, in_raw_y_ff};

   always_comb begin
      unique case (rotation_ff)
         ROT_90: begin
            tx_c = ry_c;
            ty_c = w_c - calc_type'(1) - rx_c;
         end
         ROT_180: begin
            tx_c = w_c - calc_type'(1) - rx_c;
            ty_c = h_c - calc_type'(1) - ry_c;
         end
         ROT_270: begin
            tx_c = h_c - calc_type'(1) - ry_c;
            ty_c = rx_c;
         end
         ROT_0: begin
            tx_c = rx_c;
            ty_c = ry_c;
         end
      endcase
   end

   assign tx = sat_point(tx_c);
   assign ty = sat_point(ty_c);

   // Start values as seen by this sample
   assign psx       = touch_active_ff ? panel_start_x_ff : tx;
   assign psy       = touch_active_ff ? start_y_ff : ty;
   assign fired_cur = touch_active_ff && panel_fired_ff;

   // Swipe-down: start above the top line and move down far enough
   assign top_lhs = PROD_BITS'(psy[POINT_BITS-2:0]) * PROD_BITS'(PERCENT) +
                    PROD_BITS'(PERCENT);
   assign drop    = {ty[POINT_BITS-1], ty} - {psy[POINT_BITS-1], psy};

   // Home: start below the bottom line, move up far enough, finish quickly
   assign low_lhs = PROD_BITS'(start_y_ff[POINT_BITS-2:0]) * PROD_BITS'(PERCENT);
   assign up      = {start_y_ff[POINT_BITS-1], start_y_ff} -
                    {last_y_ff[POINT_BITS-1], last_y_ff};
   assign up5     = WIDE_BITS'(up) * WIDE_BITS'(HOME_HEIGHT_DIV);
   assign elapsed = in_now_ff - start_time_ff;

   always_comb begin
      touch_active_in  = touch_active_ff;
      start_y_in       = start_y_ff;
      last_y_in        = last_y_ff;
      start_time_in    = start_time_ff;
      panel_start_x_in = panel_start_x_ff;
      panel_fired_in   = panel_fired_ff;
      rsp_x_in         = '0;
      rsp_y_in         = '0;
      rsp_home_in      = 1'b0;
      rsp_left_in      = 1'b0;
      rsp_right_in     = 1'b0;
      if (in_pressed_ff) begin
         rsp_x_in         = tx;
         rsp_y_in         = ty;
         touch_active_in  = 1'b1;
         start_y_in       = psy;
         panel_start_x_in = psx;
         panel_fired_in   = fired_cur;
         last_y_in        = ty;
         if (!touch_active_ff) begin
            start_time_in = in_now_ff;
         end
         if (!fired_cur && !psy[POINT_BITS-1] && (top_lhs <= top_prod_ff) &&
             (drop > $signed((POINT_BITS + 1)'(SWIPE_DOWN_MIN)))) begin
            panel_fired_in = 1'b1;
            if (psx < $signed({1'b0, half_w_ff})) begin
               rsp_left_in = 1'b1;
            end else begin
               rsp_right_in = 1'b1;
            end
         end
      end else begin
         if (touch_active_ff && !start_y_ff[POINT_BITS-1]) begin
            rsp_home_in = (low_lhs > bot_prod_ff) &&
                          (up5 > $signed({{(WIDE_BITS - SIZE_BITS){1'b0}}, eff_h_ff})) &&
                          (elapsed < TIME_BITS'(HOME_MAX_MS));
            start_y_in       = '1;
            last_y_in        = '1;
            panel_start_x_in = '1;
         end
         touch_active_in = 1'b0;
      end
   end

   // Commit touch state as the sample moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         touch_active_ff  <= 1'b0;
         start_y_ff       <= '1;
         last_y_ff        <= '1;
         start_time_ff    <= '0;
         panel_start_x_ff <= '0;
         panel_fired_ff   <= 1'b0;
      end else if (fire) begin
         touch_active_ff  <= touch_active_in;
         start_y_ff       <= start_y_in;
         last_y_ff        <= last_y_in;
         start_time_ff    <= start_time_in;
         panel_start_x_ff <= panel_start_x_in;
         panel_fired_ff   <= panel_fired_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_pressed_ff <= in_pressed_ff;
         rsp_x_ff       <= rsp_x_in;
         rsp_y_ff       <= rsp_y_in;
         rsp_home_ff    <= rsp_home_in;
         rsp_left_ff    <= rsp_left_in;
         rsp_right_ff   <= rsp_right_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pressed_out      = rsp_pressed_ff;
   assign rsp_point_x          = rsp_x_ff;
   assign rsp_point_y          = rsp_y_ff;
   assign rsp_home_gesture     = rsp_home_ff;
   assign rsp_swipe_down_left  = rsp_left_ff;
   assign rsp_swipe_down_right = rsp_right_ff;

endmodule
